// ===== hdl/uacia_pkg.sv =====
// Package for the 6551-style serial register block.
// Holds transaction payload types, configuration type and register/request codes.
// No dependencies.
package uacia_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_PEEK  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Register offsets carried in reg_sel.
    localparam logic [1:0] SEL_DATA    = 2'd0;
    localparam logic [1:0] SEL_STATUS  = 2'd1;
    localparam logic [1:0] SEL_COMMAND = 2'd2;
    localparam logic [1:0] SEL_CONTROL = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IRQ_LEVEL   = 2'd0;
    localparam logic [1:0] CFG_TICK_PERIOD = 2'd1;

    // Configuration reset values.
    localparam logic [1:0]  IRQ_LEVEL_RST   = 2'd1;
    localparam logic [15:0] TICK_PERIOD_RST = 16'd21111;

    // Status register bits and masks.
    localparam logic [7:0] STATUS_RST      = 8'h10;
    localparam logic [7:0] STATUS_TX_EMPTY = 8'h10;
    localparam logic [7:0] STATUS_RX_FULL  = 8'h08;
    localparam logic [7:0] STATUS_PRG_MASK = 8'hfb;
    localparam logic [7:0] STATUS_IRQ      = 8'h80;
    localparam logic [7:0] CMD_RESET_MASK  = 8'he0;

    // Transmit stage codes.
    localparam logic [1:0] TX_IDLE    = 2'd0;
    localparam logic [1:0] TX_SENDING = 2'd1;
    localparam logic [1:0] TX_WAITING = 2'd2;

    // One input transaction.
    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] reg_sel;
        logic [7:0] write_data;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] irq_out;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_taken;
    } t_out_item;

    // Configuration values handed to the register core.
    typedef struct packed {
        logic [1:0]  irq_level;
        logic [15:0] tick_period;
    } t_cfg;

endpackage

// ===== hdl/uart_acia_register_block.sv =====
// Top level of the 6551-style serial register block: handshakes, configuration
// registers and the result register. Depends on uacia_pkg and uacia_core.
//
//  Channel   Direction  Handshake            Payload
//  in        input      i_in_valid/o_in_stall    i_in_item  (t_in_item)
//  out       output     o_out_valid/i_out_stall  o_out_item (t_out_item)
//  cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each transaction passes through the register core into the result
// register, so one item is accepted per cycle while results are drained.
// Input is stalled only while the result register is full and its consumer stalls.
// Reset is synchronous and active low.
// Configuration writes are always ready; unknown indexes are ignored.
module uart_acia_register_block (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  uacia_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output uacia_pkg::t_out_item  o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    import uacia_pkg::*;

    t_cfg      r_cfg;
    t_out_item core_result;
    t_out_item r_out_item;
    logic      r_out_valid;
    logic      in_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.irq_level   <= IRQ_LEVEL_RST;
            r_cfg.tick_period <= TICK_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IRQ_LEVEL:   r_cfg.irq_level   <= i_cfg_data[1:0];
                CFG_TICK_PERIOD: r_cfg.tick_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    uacia_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // Result register: loads on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= core_result;
        end
    end

    // Every accepted transaction produces a pending result next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transaction produced no result");

    // A held result is not overwritten while its consumer stalls.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !in_accept)
        else $error("input accepted over a stalled result");

    // A nonzero interrupt output only appears with a nonzero configured level.
    a_irq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (core_result.irq_out != 2'd0)) |-> (r_cfg.irq_level != 2'd0))
        else $error("interrupt level driven that was never configured");

endmodule

// ===== hdl/uacia_core.sv =====
// Register core of the 6551-style serial block: holds all register state and
// computes one result per accepted transaction. Depends on uacia_pkg.
module uacia_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  uacia_pkg::t_in_item i_item,
    input  uacia_pkg::t_cfg     i_cfg,
    output uacia_pkg::t_out_item o_result
);
    import uacia_pkg::*;

    logic [7:0]  r_tx_hold,     n_tx_hold;
    logic [7:0]  r_rx_hold,     n_rx_hold;
    logic [7:0]  r_status,      n_status;
    logic [7:0]  r_command,     n_command;
    logic [7:0]  r_control,     n_control;
    logic [1:0]  r_tx_stage,    n_tx_stage;
    logic        r_irq_pending, n_irq_pending;
    logic        r_port_open,   n_port_open;
    logic        r_alarm_armed, n_alarm_armed;
    logic [15:0] r_alarm_count, n_alarm_count;

    // Next-state and result logic for one transaction.
    always_comb begin
        n_tx_hold     = r_tx_hold;
        n_rx_hold     = r_rx_hold;
        n_status      = r_status;
        n_command     = r_command;
        n_control     = r_control;
        n_tx_stage    = r_tx_stage;
        n_irq_pending = r_irq_pending;
        n_port_open   = r_port_open;
        n_alarm_armed = r_alarm_armed;
        n_alarm_count = r_alarm_count;
        o_result      = '0;

        if (i_item.req_type == REQ_WRITE) begin
            case (i_item.reg_sel)
                SEL_DATA: begin
                    n_tx_hold = i_item.write_data;
                    if (r_command[0]) begin
                        if (r_tx_stage == TX_IDLE) begin
                            n_alarm_armed = 1'b1;
                            n_alarm_count = 16'd1;
                            n_tx_stage    = TX_WAITING;
                        end else if (r_tx_stage == TX_SENDING) begin
                            n_tx_stage = TX_WAITING;
                        end
                        n_status = r_status & ~STATUS_TX_EMPTY;
                    end
                end
                SEL_STATUS: begin
                    // Programmed reset.
                    n_port_open   = 1'b0;
                    n_status      = r_status & STATUS_PRG_MASK;
                    n_command     = r_command & CMD_RESET_MASK;
                    n_tx_stage    = TX_IDLE;
                    n_irq_pending = 1'b0;
                    n_alarm_armed = 1'b0;
                end
                SEL_COMMAND: begin
                    n_command = i_item.write_data;
                    if (i_item.write_data[0] && !r_port_open) begin
                        n_port_open   = 1'b1;
                        n_alarm_armed = 1'b1;
                        n_alarm_count = i_cfg.tick_period;
                    end else if (r_port_open && !i_item.write_data[0]) begin
                        n_port_open   = 1'b0;
                        n_alarm_armed = 1'b0;
                    end
                end
                default: begin
                    n_control = i_item.write_data;
                end
            endcase
        end else if (i_item.req_type inside {REQ_READ, REQ_PEEK}) begin
            case (i_item.reg_sel)
                SEL_DATA: begin
                    o_result.read_data = r_rx_hold;
                    if (i_item.req_type == REQ_READ) begin
                        n_status = r_status & ~STATUS_RX_FULL;
                    end
                end
                SEL_STATUS: begin
                    o_result.read_data = r_status | (r_irq_pending ? STATUS_IRQ : 8'h00);
                    if (i_item.req_type == REQ_READ) begin
                        n_irq_pending = 1'b0;
                    end
                end
                SEL_COMMAND: begin
                    o_result.read_data = r_command;
                end
                default: begin
                    o_result.read_data = r_control;
                end
            endcase
        end else if (r_alarm_armed) begin
            // Clock tick: count down, service on expiry.
            if (r_alarm_count <= 16'd1) begin
                if (r_tx_stage == TX_WAITING && r_port_open) begin
                    o_result.tx_valid = 1'b1;
                    o_result.tx_byte  = r_tx_hold;
                end
                if (r_tx_stage != TX_IDLE) begin
                    n_tx_stage = r_tx_stage - 2'd1;
                end
                n_status = r_status | STATUS_TX_EMPTY;
                if (r_port_open && !r_status[3] && i_item.rx_valid) begin
                    n_rx_hold         = i_item.rx_byte;
                    n_status          = r_status | STATUS_TX_EMPTY | STATUS_RX_FULL;
                    o_result.rx_taken = 1'b1;
                end
                n_irq_pending = 1'b1;
                n_alarm_armed = 1'b1;
                n_alarm_count = i_cfg.tick_period;
            end else begin
                n_alarm_count = r_alarm_count - 16'd1;
            end
        end

        o_result.irq_out = n_irq_pending ? i_cfg.irq_level : 2'd0;
    end

    // State registers, updated once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_hold     <= '0;
            r_rx_hold     <= '0;
            r_status      <= STATUS_RST;
            r_command     <= '0;
            r_control     <= '0;
            r_tx_stage    <= TX_IDLE;
            r_irq_pending <= 1'b0;
            r_port_open   <= 1'b0;
            r_alarm_armed <= 1'b0;
            r_alarm_count <= '0;
        end else if (i_accept) begin
            r_tx_hold     <= n_tx_hold;
            r_rx_hold     <= n_rx_hold;
            r_status      <= n_status;
            r_command     <= n_command;
            r_control     <= n_control;
            r_tx_stage    <= n_tx_stage;
            r_irq_pending <= n_irq_pending;
            r_port_open   <= n_port_open;
            r_alarm_armed <= n_alarm_armed;
            r_alarm_count <= n_alarm_count;
        end
    end

    // The transmit stage never reaches the unused code.
    a_stage_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_stage != 2'd3)
        else $error("transmit stage holds an unused code");

    // Command bit 0 always mirrors the port-open flag.
    a_open_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_command[0] == r_port_open)
        else $error("command bit 0 and port-open flag disagree");

    // The periodic alarm only runs while the port is open.
    a_alarm_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alarm_armed |-> r_port_open)
        else $error("alarm armed while port closed");

    // A latched receive byte leaves receive-full set.
    a_rx_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.rx_taken) |=> r_status[3])
        else $error("receive-full not set after a byte was latched");

    // Only status bits 4 down to 2, among them transmitter-empty and receive-full, are ever used.
    a_status_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status[7:5] == 3'd0) && (r_status[1:0] == 2'd0))
        else $error("unused status bit set");

endmodule

// ===== tb/tb_uart_acia_register_block.sv =====
// Self-checking testbench for the 6551-style serial register block.
// Predicts every response from its own model of the registers, alarm and transmit stages.
// Depends on uacia_pkg and uart_acia_register_block.
module tb_uart_acia_register_block;
    timeunit 1ns;
    timeprecision 1ps;

    import uacia_pkg::*;

    // Index that maps to no configuration register; writes to it must be ignored.
    localparam logic [1:0]  CFG_SPARE   = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Predicts the register block and checks its responses in order.
    class acia_scoreboard;
        logic [1:0]  irq_level;
        logic [15:0] tick_period;
        logic [7:0]  tx_hold;
        logic [7:0]  rx_hold;
        logic [7:0]  status_bits;
        logic [7:0]  command_reg;
        logic [7:0]  control_reg;
        logic [1:0]  tx_stage;
        logic        irq_pending;
        logic        port_open;
        logic        alarm_armed;
        logic [15:0] alarm_count;
        t_out_item   expected_responses[$];
        int          error_count;

        function new();
            irq_level   = IRQ_LEVEL_RST;
            tick_period = TICK_PERIOD_RST;
            tx_hold     = 8'h00;
            rx_hold     = 8'h00;
            status_bits = STATUS_RST;
            command_reg = 8'h00;
            control_reg = 8'h00;
            tx_stage    = TX_IDLE;
            irq_pending = 1'b0;
            port_open   = 1'b0;
            alarm_armed = 1'b0;
            alarm_count = 16'd0;
            error_count = 0;
        endfunction

        function void write_config(logic [1:0] index, logic [15:0] data);
            if (index == CFG_IRQ_LEVEL) begin
                irq_level = data[1:0];
            end else if (index == CFG_TICK_PERIOD) begin
                tick_period = data;
            end
        endfunction

        // Applies one bus access or tick to the register state and returns its response.
        function t_out_item acia_response(t_in_item req);
            t_out_item rsp;
            rsp = '0;
            case (req.req_type)
                REQ_WRITE: begin
                    case (req.reg_sel)
                        SEL_DATA: begin
                            tx_hold = req.write_data;
                            // With the port enabled, a byte starts a short or queued transmit.
                            if (command_reg[0]) begin
                                if (tx_stage == TX_IDLE) begin
                                    alarm_armed = 1'b1;
                                    alarm_count = 16'd1;
                                    tx_stage    = TX_WAITING;
                                end else if (tx_stage == TX_SENDING) begin
                                    tx_stage = TX_WAITING;
                                end
                                status_bits &= ~STATUS_TX_EMPTY;
                            end
                        end
                        SEL_STATUS: begin
                            // Programmed reset.
                            port_open   = 1'b0;
                            status_bits &= STATUS_PRG_MASK;
                            command_reg &= CMD_RESET_MASK;
                            tx_stage    = TX_IDLE;
                            irq_pending = 1'b0;
                            alarm_armed = 1'b0;
                        end
                        SEL_COMMAND: begin
                            command_reg = req.write_data;
                            if (req.write_data[0] && !port_open) begin
                                port_open   = 1'b1;
                                alarm_armed = 1'b1;
                                alarm_count = tick_period;
                            end else if (port_open && !req.write_data[0]) begin
                                port_open   = 1'b0;
                                alarm_armed = 1'b0;
                            end
                        end
                        default: begin
                            control_reg = req.write_data;
                        end
                    endcase
                end
                REQ_READ, REQ_PEEK: begin
                    case (req.reg_sel)
                        SEL_DATA: begin
                            rsp.read_data = rx_hold;
                            if (req.req_type == REQ_READ) begin
                                status_bits &= ~STATUS_RX_FULL;
                            end
                        end
                        SEL_STATUS: begin
                            rsp.read_data = status_bits | (irq_pending ? STATUS_IRQ : 8'h00);
                            if (req.req_type == REQ_READ) begin
                                irq_pending = 1'b0;
                            end
                        end
                        SEL_COMMAND: begin
                            rsp.read_data = command_reg;
                        end
                        default: begin
                            rsp.read_data = control_reg;
                        end
                    endcase
                end
                default: begin
                    // Only ticks advance the alarm; a count of zero or one expires now.
                    if (alarm_armed) begin
                        if (alarm_count <= 16'd1) begin
                            if (tx_stage == TX_WAITING && port_open) begin
                                rsp.tx_valid = 1'b1;
                                rsp.tx_byte  = tx_hold;
                            end
                            if (tx_stage != TX_IDLE) begin
                                tx_stage = tx_stage - 2'd1;
                            end
                            status_bits |= STATUS_TX_EMPTY;
                            if (port_open && (status_bits & STATUS_RX_FULL) == 8'h00
                                    && req.rx_valid) begin
                                rx_hold      = req.rx_byte;
                                status_bits |= STATUS_RX_FULL;
                                rsp.rx_taken = 1'b1;
                            end
                            irq_pending = 1'b1;
                            alarm_count = tick_period;
                        end else begin
                            alarm_count = alarm_count - 16'd1;
                        end
                    end
                end
            endcase
            rsp.irq_out = irq_pending ? irq_level : 2'd0;
            return rsp;
        endfunction

        function void note_request(t_in_item req);
            expected_responses.push_back(acia_response(req));
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_response(t_out_item got);
            t_out_item want;
            if (expected_responses.size() == 0) begin
                $error("response %h arrived with none expected", got);
                error_count++;
                return;
            end
            want = expected_responses.pop_front();
            check_field("read_data", want.read_data, got.read_data);
            check_field("irq_out", 8'(want.irq_out), 8'(got.irq_out));
            check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
            check_field("tx_byte", want.tx_byte, got.tx_byte);
            check_field("rx_taken", 8'(want.rx_taken), 8'(got.rx_taken));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    acia_scoreboard sb;
    int unsigned    cycle_count = 0;
    int unsigned    idle_pct;
    int unsigned    stall_pct;
    logic [1:0]     phase_level;
    logic [15:0]    phase_period;

    uart_acia_register_block uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_uart_acia_register_block NOT OK");
            $finish;
        end
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Observes every accepted transaction on all three channels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_config(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(i_in_item);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_response(o_out_item);
            end
        end
    end

    function automatic t_in_item make_request(logic [1:0] req_type, logic [1:0] reg_sel,
                                              logic [7:0] write_data, logic rx_valid,
                                              logic [7:0] rx_byte);
        t_in_item req;
        req.req_type   = req_type;
        req.reg_sel    = reg_sel;
        req.write_data = write_data;
        req.rx_valid   = rx_valid;
        req.rx_byte    = rx_byte;
        return req;
    endfunction

    // Mostly ticks and data writes with the port open; unused fields carry noise.
    function automatic t_in_item random_request();
        t_in_item    req;
        int unsigned pick;
        req.write_data = 8'($urandom_range(255));
        req.rx_valid   = ($urandom_range(99) < 70);
        req.rx_byte    = 8'($urandom_range(255));
        req.reg_sel    = 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 40) begin
            req.req_type = REQ_TICK;
        end else if (pick < 65) begin
            req.req_type = REQ_WRITE;
            pick = $urandom_range(99);
            if (pick < 60) begin
                req.reg_sel = SEL_DATA;
            end else if (pick < 82) begin
                req.reg_sel       = SEL_COMMAND;
                req.write_data[0] = ($urandom_range(99) < 75);
            end else if (pick < 90) begin
                req.reg_sel = SEL_STATUS;
            end else begin
                req.reg_sel = SEL_CONTROL;
            end
        end else if (pick < 88) begin
            req.req_type = REQ_READ;
        end else begin
            req.req_type = REQ_PEEK;
        end
        return req;
    endfunction

    // Sends one transaction after a random idle gap; returns at the accepting edge.
    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_item  <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_config_reg(input logic [1:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Writes both registers, and the spare index if asked; the level write carries junk in its upper bits.
    task automatic configure(input logic [1:0] level, input logic [15:0] period,
                             input bit with_spare);
        logic [13:0] junk;
        junk = 14'($urandom);
        write_config_reg(CFG_IRQ_LEVEL, {junk, level});
        write_config_reg(CFG_TICK_PERIOD, period);
        if (with_spare) begin
            write_config_reg(CFG_SPARE, 16'hffff);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every expected response has been checked.
    task automatic drain_responses();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        idle_pct    = 0;
        stall_pct   = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IRQ_LEVEL;
        i_cfg_data  <= 16'h0000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sequence under the reset configuration.
        send_request(make_request(REQ_PEEK, SEL_STATUS, 8'hff, 1'b1, 8'hff));
        send_request(make_request(REQ_READ, SEL_DATA, 8'h00, 1'b0, 8'h00));
        send_request(make_request(REQ_PEEK, SEL_COMMAND, 8'h00, 1'b1, 8'h00));
        send_request(make_request(REQ_PEEK, SEL_CONTROL, 8'hff, 1'b0, 8'hff));
        send_request(make_request(REQ_WRITE, SEL_CONTROL, 8'hff, 1'b1, 8'hff));
        send_request(make_request(REQ_READ, SEL_CONTROL, 8'h00, 1'b0, 8'h00));
        // Data write with the port disabled only loads the transmit byte.
        send_request(make_request(REQ_WRITE, SEL_DATA, 8'ha5, 1'b0, 8'h00));
        // Offered byte while no alarm is armed is dropped.
        send_request(make_request(REQ_TICK, SEL_DATA, 8'h00, 1'b1, 8'h00));
        send_request(make_request(REQ_WRITE, SEL_COMMAND, 8'h01, 1'b0, 8'h00));
        send_request(make_request(REQ_WRITE, SEL_DATA, 8'h5a, 1'b0, 8'h00));
        // A second write while a byte waits replaces it.
        send_request(make_request(REQ_WRITE, SEL_DATA, 8'hc3, 1'b0, 8'h00));
        send_request(make_request(REQ_PEEK, SEL_STATUS, 8'h00, 1'b0, 8'h00));
        // Short transmit expires: sends, takes the byte and raises the interrupt.
        send_request(make_request(REQ_TICK, SEL_STATUS, 8'h00, 1'b1, 8'hff));
        send_request(make_request(REQ_PEEK, SEL_STATUS, 8'h00, 1'b0, 8'h00));
        send_request(make_request(REQ_READ, SEL_STATUS, 8'h00, 1'b0, 8'h00));
        send_request(make_request(REQ_READ, SEL_STATUS, 8'h00, 1'b0, 8'h00));
        // Tick that does not expire the alarm drops the offered byte.
        send_request(make_request(REQ_TICK, SEL_CONTROL, 8'h00, 1'b1, 8'h77));
        send_request(make_request(REQ_WRITE, SEL_DATA, 8'h00, 1'b0, 8'h00));
        send_request(make_request(REQ_READ, SEL_DATA, 8'h00, 1'b0, 8'h00));
        send_request(make_request(REQ_READ, SEL_COMMAND, 8'h00, 1'b0, 8'h00));
        send_request(make_request(REQ_WRITE, SEL_STATUS, 8'h00, 1'b0, 8'h00));
        send_request(make_request(REQ_PEEK, SEL_COMMAND, 8'h00, 1'b0, 8'h00));
        send_request(make_request(REQ_WRITE, SEL_COMMAND, 8'hfe, 1'b0, 8'h00));
        send_request(make_request(REQ_WRITE, SEL_COMMAND, 8'h00, 1'b0, 8'h00));
        send_request(make_request(REQ_PEEK, SEL_STATUS, 8'h00, 1'b0, 8'h00));

        // Random phases, each with its own configuration and handshake pressure.
        for (int phase = 0; phase < 6; phase++) begin
            drain_responses();
            case (phase)
                0: begin
                    phase_level = 2'd3; phase_period = 16'd1;     idle_pct = 0;  stall_pct = 0;
                end
                1: begin
                    phase_level = 2'd0; phase_period = 16'd2;     idle_pct = 70; stall_pct = 0;
                end
                2: begin
                    phase_level = 2'd2; phase_period = 16'd3;     idle_pct = 0;  stall_pct = 70;
                end
                3: begin
                    phase_level  = 2'd1;
                    phase_period = 16'($urandom_range(8, 1));
                    idle_pct     = 18;
                    stall_pct    = 18;
                end
                4: begin
                    // A zero period behaves as a period of one.
                    phase_level = 2'd3; phase_period = 16'd0;     idle_pct = 0;  stall_pct = 0;
                end
                default: begin
                    phase_level = 2'd2; phase_period = 16'hffff;  idle_pct = 18; stall_pct = 18;
                end
            endcase
            configure(phase_level, phase_period, phase == 0);
            repeat (150) send_request(random_request());
        end

        drain_responses();
        repeat (8) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("tb_uart_acia_register_block OK");
        end else begin
            $display("tb_uart_acia_register_block NOT OK");
        end
        $finish;
    end

endmodule
